[hdl/fpc_pkg.sv]
// Shared types and constants of the float pump controller.
// Holds register codes, reset values, pipeline structs and the ring geometry.
// Depends on nothing; used by every other file of the block but fpc_ram.
package fpc_pkg;

    // Hourly ring of cumulative low-time totals
    localparam int HOUR_SLOTS = 25;
    localparam int SLOT_W     = $clog2(HOUR_SLOTS);

    // Milliseconds to seconds: x / 1000 == (x * SEC_RECIP) >> SEC_SHIFT for all 32-bit x
    localparam int              RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] SEC_RECIP = 29'd274877907;
    localparam int              SEC_SHIFT = 38;
    localparam int              PROD_W    = 32 + RECIP_W;
    localparam int              QUOT_W    = PROD_W - SEC_SHIFT;

    // Configuration register codes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_PUMP_RUN  = 3'd1,
        REG_PUMP_REST = 3'd2,
        REG_LOW_ALARM = 3'd3,
        REG_HOUR_LEN  = 3'd4,
        REG_ALARM_EN  = 3'd5
    } cfg_reg_t;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd50;
    localparam logic [31:0] PUMP_RUN_RST  = 32'd60000;
    localparam logic [31:0] PUMP_REST_RST = 32'd60000;
    localparam logic [31:0] LOW_ALARM_RST = 32'd3600000;
    localparam logic [31:0] HOUR_LEN_RST  = 32'd3600000;
    localparam logic        ALARM_EN_RST  = 1'b1;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [31:0] pump_run_ms;
        logic [31:0] pump_rest_ms;
        logic [31:0] low_alarm_ms;
        logic [31:0] hour_length_ms;
        logic        alarm_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_FULL  = 2'd2
    } level_ev_t;

    // What a pass does to the ring and to the running low total
    typedef enum logic [1:0] {
        RING_HOLD  = 2'd0,  // write the running total into the current slot
        RING_LOW   = 2'd1,  // write running total plus elapsed low seconds
        RING_LEAVE = 2'd2   // fold elapsed low seconds into the total, no write
    } ring_op_t;

    typedef struct packed {
        logic        pump_on;
        level_ev_t   level_event;
        logic        alarm_pulse;
        logic        trough_empty;
        logic [31:0] low_event_count;
    } flag_set_t;

    typedef struct packed {
        logic              valid;
        ring_op_t          op;
        logic [31:0]       low_for;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] oldest;
        flag_set_t         flags;
    } ring_req_t;

    typedef struct packed {
        flag_set_t   flags;
        logic [31:0] low_secs_24h;
    } result_t;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = FIFO_PTR_W + 1;

endpackage

[hdl/fpc_if.sv]
// Channel interfaces of the float pump controller: pass items, result items, config writes.
// Depends on fpc_pkg for the register index width.
interface fpc_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;
    logic        float_raw;

    modport source (output valid, output now_ms, output float_raw, input ready);
    modport sink   (input valid, input now_ms, input float_raw, output ready);
endinterface

interface fpc_result_if;
    logic        valid;
    logic        ready;
    logic        pump_on;
    logic [1:0]  level_event;
    logic        alarm_pulse;
    logic        trough_empty;
    logic [31:0] low_secs_24h;
    logic [31:0] low_event_count;

    modport source (output valid, output pump_on, output level_event, output alarm_pulse,
                    output trough_empty, output low_secs_24h, output low_event_count,
                    input ready);
    modport sink   (input valid, input pump_on, input level_event, input alarm_pulse,
                    input trough_empty, input low_secs_24h, input low_event_count,
                    output ready);
endinterface

interface fpc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fpc_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/float_pump_controller.sv]
// Top level of the float pump controller: config registers, occupancy credit, assertions.
// Depends on fpc_pkg, fpc_if, fpc_ctrl, fpc_ring (with fpc_ram) and fpc_fifo.
//
// Usage
//   sample : one control pass per item (now_ms, float_raw), valid/ready.
//   result : one result item per pass, in order (pump drive, level event, alarm pulse,
//            empty flag, low seconds over the last day, count of low events).
//   cfg    : register writes (index, data); always ready. Write only while idle.
// Throughput: one item per cycle. The ring memory is read for the newest and oldest
//   slot in the same cycle from two mirrored copies, so nothing limits the rate below
//   one pass per clock while the result side keeps taking items.
// Pipeline: an accepted item passes the control state, the seconds multiply, the ring
//   read/modify/write and the output queue before the result can be taken.
// Stall: results wait in an 8-item queue. sample.ready drops once 8 items are in
//   flight or waiting, and rises again as the receiver takes results.
// Reset: all control state and the registers return to their reset values. The ring
//   memory is not swept; a valid bit per slot is cleared at once and an unwritten slot
//   reads as zero, so the block takes items as soon as reset is released.
module float_pump_controller (
    input  logic                clk,
    input  logic                rst_n,
    fpc_sample_if.sink          sample,
    fpc_result_if.source        result,
    fpc_cfg_if.sink             cfg
);

    fpc_pkg::cfg_t             cfg_reg, cfg_next;
    logic [fpc_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic                      take;
    logic                      pop;
    fpc_pkg::ring_req_t        req;
    logic                      res_valid;
    fpc_pkg::result_t          res;
    fpc_pkg::result_t          head;

    // Configuration writes: decode the index, ignore codes beyond the register list
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (fpc_pkg::cfg_reg_t'(cfg.index))
                fpc_pkg::REG_DEBOUNCE:  cfg_next.debounce_ms    = cfg.data[15:0];
                fpc_pkg::REG_PUMP_RUN:  cfg_next.pump_run_ms    = cfg.data;
                fpc_pkg::REG_PUMP_REST: cfg_next.pump_rest_ms   = cfg.data;
                fpc_pkg::REG_LOW_ALARM: cfg_next.low_alarm_ms   = cfg.data;
                fpc_pkg::REG_HOUR_LEN:  cfg_next.hour_length_ms = cfg.data;
                fpc_pkg::REG_ALARM_EN:  cfg_next.alarm_enable   = cfg.data[0];
                default:                cfg_next                = cfg_reg;
            endcase
        end
    end

    // Occupancy credit: items accepted and not yet taken at the result side.
    // Holding it at the queue depth keeps the queue from overflowing without
    // any stall inside the pipeline.
    assign take         = sample.valid && sample.ready;
    assign pop          = result.valid && result.ready;
    assign sample.ready = (occ_reg < fpc_pkg::OCC_W'(fpc_pkg::FIFO_DEPTH));

    always_comb
    begin
        occ_next = occ_reg;
        if (take && !pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (!take && pop)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms    <= fpc_pkg::DEBOUNCE_RST;
            cfg_reg.pump_run_ms    <= fpc_pkg::PUMP_RUN_RST;
            cfg_reg.pump_rest_ms   <= fpc_pkg::PUMP_REST_RST;
            cfg_reg.low_alarm_ms   <= fpc_pkg::LOW_ALARM_RST;
            cfg_reg.hour_length_ms <= fpc_pkg::HOUR_LEN_RST;
            cfg_reg.alarm_enable   <= fpc_pkg::ALARM_EN_RST;
            occ_reg                <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            occ_reg <= occ_next;
        end
    end

    // Control state advances on every accepted pass
    fpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (cfg_reg),
        .take      (take),
        .now_ms    (sample.now_ms),
        .float_raw (sample.float_raw),
        .req       (req)
    );

    // Seconds conversion, running total and the hourly ring
    fpc_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res       (res)
    );

    // Hold finished results until the receiver takes them
    fpc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .out_valid (result.valid),
        .out_data  (head)
    );

    assign result.pump_on         = head.flags.pump_on;
    assign result.level_event     = head.flags.level_event;
    assign result.alarm_pulse     = head.flags.alarm_pulse;
    assign result.trough_empty    = head.flags.trough_empty;
    assign result.low_secs_24h    = head.low_secs_24h;
    assign result.low_event_count = head.flags.low_event_count;

    // The credit never exceeds the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= fpc_pkg::OCC_W'(fpc_pkg::FIFO_DEPTH))
        else $error("occupancy credit above queue depth");

    // Going empty starts a run phase in the same pass
    a_empty_event: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.level_event == fpc_pkg::EV_EMPTY))
        |-> (result.trough_empty && result.pump_on))
        else $error("empty event without empty state and running pump");

    // Going full stops the pump and leaves the empty state
    a_full_event: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.level_event == fpc_pkg::EV_FULL))
        |-> (!result.trough_empty && !result.pump_on))
        else $error("full event with empty state or running pump");

    // The alarm fires only while low, never on a pass that changes state
    a_alarm_low: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.alarm_pulse)
        |-> (result.trough_empty && (result.level_event == fpc_pkg::EV_NONE)))
        else $error("alarm pulse outside a steady empty pass");

endmodule

[hdl/fpc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module fpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/fpc_ctrl.sv]
// Per-pass control state: debounce, full/empty machine, pump phases, alarm, hour slot.
// Depends on fpc_pkg; feeds one ring request per accepted item to fpc_ring.
module fpc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  fpc_pkg::cfg_t      regs,
    input  logic               take,
    input  logic [31:0]        now_ms,
    input  logic               float_raw,
    output fpc_pkg::ring_req_t req
);

    localparam logic [fpc_pkg::SLOT_W-1:0] LAST_SLOT = fpc_pkg::SLOT_W'(fpc_pkg::HOUR_SLOTS - 1);

    logic                        last_raw_reg,    last_raw_next;
    logic                        stable_reg,      stable_next;
    logic [31:0]                 change_stamp_reg, change_stamp_next;
    logic                        full_reg,        full_next;
    logic                        empty_reg,       empty_next;
    logic                        run_reg,         run_next;
    logic                        rest_reg,        rest_next;
    logic [31:0]                 run_stamp_reg,   run_stamp_next;
    logic [31:0]                 rest_stamp_reg,  rest_stamp_next;
    logic [31:0]                 empty_stamp_reg, empty_stamp_next;
    logic                        alarm_sent_reg,  alarm_sent_next;
    logic [31:0]                 hour_stamp_reg,  hour_stamp_next;
    logic [fpc_pkg::SLOT_W-1:0]  slot_reg,        slot_next;
    logic [31:0]                 down_count_reg,  down_count_next;
    logic                        pump_reg,        pump_next;
    fpc_pkg::ring_req_t          req_reg,         req_next;

    always_comb
    begin
        fpc_pkg::level_ev_t         ev;
        fpc_pkg::ring_op_t          op;
        logic                       pulse;
        logic [31:0]                low_for;
        logic [fpc_pkg::SLOT_W-1:0] oldest;

        ev      = fpc_pkg::EV_NONE;
        op      = fpc_pkg::RING_HOLD;
        pulse   = 1'b0;
        low_for = '0;

        // Debounce: take the raw level once it has held longer than the window
        change_stamp_next = change_stamp_reg;
        if (float_raw != last_raw_reg)
        begin
            change_stamp_next = now_ms;
        end
        stable_next = stable_reg;
        if ((now_ms - change_stamp_next) > {16'd0, regs.debounce_ms})
        begin
            stable_next = float_raw;
        end
        last_raw_next = float_raw;

        full_next        = full_reg;
        empty_next       = empty_reg;
        run_next         = run_reg;
        rest_next        = rest_reg;
        run_stamp_next   = run_stamp_reg;
        rest_stamp_next  = rest_stamp_reg;
        empty_stamp_next = empty_stamp_reg;
        alarm_sent_next  = alarm_sent_reg;
        down_count_next  = down_count_reg;

        // Full state
        if (full_reg)
        begin
            if (!stable_next)
            begin
                empty_next       = 1'b1;
                full_next        = 1'b0;
                run_next         = 1'b1;
                rest_next        = 1'b0;
                run_stamp_next   = now_ms;
                empty_stamp_next = now_ms;
                down_count_next  = down_count_reg + 32'd1;
                ev               = fpc_pkg::EV_EMPTY;
            end
            op = fpc_pkg::RING_HOLD;
        end

        // Empty state, also on the pass that entered it
        if (empty_next)
        begin
            low_for = now_ms - empty_stamp_next;
            if (stable_next)
            begin
                empty_next      = 1'b0;
                full_next       = 1'b1;
                run_next        = 1'b0;
                rest_next       = 1'b1;
                alarm_sent_next = 1'b0;
                ev              = fpc_pkg::EV_FULL;
                op              = fpc_pkg::RING_LEAVE;
            end
            else
            begin
                op = fpc_pkg::RING_LOW;
                if (run_next && ((now_ms - run_stamp_next) > regs.pump_run_ms))
                begin
                    run_next        = 1'b0;
                    rest_next       = 1'b1;
                    rest_stamp_next = now_ms;
                end
                if (rest_next && ((now_ms - rest_stamp_next) > regs.pump_rest_ms))
                begin
                    run_next       = 1'b1;
                    rest_next      = 1'b0;
                    run_stamp_next = now_ms;
                end
                if ((low_for > regs.low_alarm_ms) && !alarm_sent_reg && regs.alarm_enable)
                begin
                    alarm_sent_next = 1'b1;
                    pulse           = 1'b1;
                end
            end
        end

        // Ring slots seen by this pass, then the hour advance
        oldest = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        hour_stamp_next = hour_stamp_reg;
        slot_next       = slot_reg;
        if ((now_ms - hour_stamp_reg) > regs.hour_length_ms)
        begin
            hour_stamp_next = now_ms;
            slot_next       = oldest;
        end

        // Pump drive holds when neither phase is active
        pump_next = pump_reg;
        if (run_next)
        begin
            pump_next = 1'b1;
        end
        if (rest_next)
        begin
            pump_next = 1'b0;
        end

        req_next.valid                 = take;
        req_next.op                    = op;
        req_next.low_for               = low_for;
        req_next.slot                  = slot_reg;
        req_next.oldest                = oldest;
        req_next.flags.pump_on         = pump_next;
        req_next.flags.level_event     = ev;
        req_next.flags.alarm_pulse     = pulse;
        req_next.flags.trough_empty    = empty_next;
        req_next.flags.low_event_count = down_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b1;
            stable_reg       <= 1'b1;
            change_stamp_reg <= '0;
            full_reg         <= 1'b1;
            empty_reg        <= 1'b0;
            run_reg          <= 1'b0;
            rest_reg         <= 1'b0;
            run_stamp_reg    <= '0;
            rest_stamp_reg   <= '0;
            empty_stamp_reg  <= '0;
            alarm_sent_reg   <= 1'b0;
            hour_stamp_reg   <= '0;
            slot_reg         <= '0;
            down_count_reg   <= '0;
            pump_reg         <= 1'b0;
            req_reg          <= '0;
        end
        else
        begin
            req_reg <= req_next;
            if (take)
            begin
                last_raw_reg     <= last_raw_next;
                stable_reg       <= stable_next;
                change_stamp_reg <= change_stamp_next;
                full_reg         <= full_next;
                empty_reg        <= empty_next;
                run_reg          <= run_next;
                rest_reg         <= rest_next;
                run_stamp_reg    <= run_stamp_next;
                rest_stamp_reg   <= rest_stamp_next;
                empty_stamp_reg  <= empty_stamp_next;
                alarm_sent_reg   <= alarm_sent_next;
                hour_stamp_reg   <= hour_stamp_next;
                slot_reg         <= slot_next;
                down_count_reg   <= down_count_next;
                pump_reg         <= pump_next;
            end
        end
    end

    assign req = req_reg;

endmodule

[hdl/fpc_ring.sv]
// Low-time accounting: seconds conversion, running total and the hourly ring memory.
// Depends on fpc_pkg and fpc_ram; takes requests from fpc_ctrl, produces results.
module fpc_ring (
    input  logic               clk,
    input  logic               rst_n,
    input  fpc_pkg::ring_req_t req,
    output logic               res_valid,
    output fpc_pkg::result_t   res
);

    // Convert milliseconds to whole seconds by reciprocal multiply
    logic [fpc_pkg::PROD_W-1:0] prod;
    assign prod = fpc_pkg::PROD_W'(req.low_for) * fpc_pkg::PROD_W'(fpc_pkg::SEC_RECIP);

    logic                        a_valid_reg;
    fpc_pkg::ring_op_t           a_op_reg;
    logic [fpc_pkg::QUOT_W-1:0]  a_quot_reg;
    logic [fpc_pkg::SLOT_W-1:0]  a_slot_reg;
    logic [fpc_pkg::SLOT_W-1:0]  a_oldest_reg;
    fpc_pkg::flag_set_t          a_flags_reg;

    logic [31:0]                 total_reg, total_next;
    logic [fpc_pkg::HOUR_SLOTS-1:0] valid_reg, valid_next;
    logic                        we;
    logic [31:0]                 wdata;
    logic [31:0]                 sum;

    logic                        b_valid_reg;
    logic                        b_wr_reg;
    logic [31:0]                 b_wdata_reg;
    logic                        b_vnew_reg;
    logic                        b_vold_reg;
    fpc_pkg::flag_set_t          b_flags_reg;
    logic [31:0]                 rd_new;
    logic [31:0]                 rd_old;

    assign sum = total_reg + {{(32 - fpc_pkg::QUOT_W){1'b0}}, a_quot_reg};

    always_comb
    begin
        we         = 1'b0;
        wdata      = total_reg;
        total_next = total_reg;
        unique case (a_op_reg)
            fpc_pkg::RING_HOLD:
            begin
                we    = a_valid_reg;
                wdata = total_reg;
            end
            fpc_pkg::RING_LOW:
            begin
                we    = a_valid_reg;
                wdata = sum;
            end
            fpc_pkg::RING_LEAVE:
            begin
                if (a_valid_reg)
                begin
                    total_next = sum;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase

        valid_next = valid_reg;
        if (we)
        begin
            valid_next[a_slot_reg] = 1'b1;
        end
    end

    // Two copies of the ring so newest and oldest slots read in the same cycle
    fpc_ram #(.WIDTH(32), .DEPTH(fpc_pkg::HOUR_SLOTS)) u_ram_new (
        .clk   (clk),
        .we    (we),
        .waddr (a_slot_reg),
        .wdata (wdata),
        .re    (a_valid_reg),
        .raddr (a_slot_reg),
        .rdata (rd_new)
    );

    fpc_ram #(.WIDTH(32), .DEPTH(fpc_pkg::HOUR_SLOTS)) u_ram_old (
        .clk   (clk),
        .we    (we),
        .waddr (a_slot_reg),
        .wdata (wdata),
        .re    (a_valid_reg),
        .raddr (a_oldest_reg),
        .rdata (rd_old)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            total_reg   <= '0;
            valid_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= req.valid;
            b_valid_reg <= a_valid_reg;
            total_reg   <= total_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_op_reg     <= req.op;
        a_quot_reg   <= prod[fpc_pkg::PROD_W-1:fpc_pkg::SEC_SHIFT];
        a_slot_reg   <= req.slot;
        a_oldest_reg <= req.oldest;
        a_flags_reg  <= req.flags;

        b_wr_reg     <= we;
        b_wdata_reg  <= wdata;
        b_vnew_reg   <= valid_reg[a_slot_reg];
        b_vold_reg   <= valid_reg[a_oldest_reg];
        b_flags_reg  <= a_flags_reg;
    end

    // Newest slot comes from this pass's write unless the pass left the empty state
    always_comb
    begin
        logic [31:0] newest;
        logic [31:0] oldest;

        newest = b_wr_reg ? b_wdata_reg : (b_vnew_reg ? rd_new : 32'd0);
        oldest = b_vold_reg ? rd_old : 32'd0;
        res.flags        = b_flags_reg;
        res.low_secs_24h = newest - oldest;
    end

    assign res_valid = b_valid_reg;

endmodule

[hdl/fpc_fifo.sv]
// Output queue of result items between the ring pipeline and the result channel.
// Depends on fpc_pkg; overflow is prevented by the occupancy credit in the top level.
module fpc_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fpc_pkg::result_t push_data,
    input  logic             pop,
    output logic             out_valid,
    output fpc_pkg::result_t out_data
);

    fpc_pkg::result_t                entry_reg [fpc_pkg::FIFO_DEPTH];
    logic [fpc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fpc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fpc_pkg::OCC_W-1:0]      count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for float_pump_controller: control passes in, result items out.
// Predicts every result from its own model of the controller state and compares in order.
// Depends on fpc_pkg, the channel interfaces in fpc_if and the controller RTL.
module testbench;

    // Spare register codes: writes to them must leave every register alone
    localparam logic [fpc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [fpc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [31:0]                   MS_PER_S     = 32'd1000;
    localparam int                            MAX_WAIT     = 11;
    localparam int                            CYCLE_LIMIT  = 400000;
    localparam int                            TAIL_CYCLES  = 16;

    logic clk;
    logic rst_n;

    fpc_sample_if pass_ch ();
    fpc_result_if res_ch ();
    fpc_cfg_if    reg_ch ();

    float_pump_controller i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (pass_ch),
        .result (res_ch),
        .cfg    (reg_ch)
    );

    // Clock: 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Controller model: register copy and the full pass state
    // ------------------------------------------------------------------
    fpc_pkg::cfg_t              regs;
    logic                       raw_prev;
    logic                       level_stable;
    logic [31:0]                raw_change_at;
    logic                       in_full;
    logic                       in_empty;
    logic                       pump_run;
    logic                       pump_rest;
    logic [31:0]                run_since;
    logic [31:0]                rest_since;
    logic [31:0]                low_since;
    logic [31:0]                low_secs_total;
    logic                       alarm_done;
    logic [31:0]                slot_started;
    logic [fpc_pkg::SLOT_W-1:0] cur_slot;
    logic [31:0]                slot_total [fpc_pkg::HOUR_SLOTS];
    logic [31:0]                empty_entries;
    logic                       pump_drive;

    // Results predicted but not yet seen on the result channel
    fpc_pkg::result_t pending_results [$];

    // Stimulus and receiver controls
    bit          src_idle;
    bit          sink_idle;
    int          hold_request;
    logic [31:0] now_cursor;

    // Run bookkeeping
    int failures;
    int cycles;
    int passes_sent;
    int results_checked;
    int empties_seen;
    int fulls_seen;
    int alarms_seen;
    int settings_applied;

    function automatic void clear_model();
        regs.debounce_ms    = fpc_pkg::DEBOUNCE_RST;
        regs.pump_run_ms    = fpc_pkg::PUMP_RUN_RST;
        regs.pump_rest_ms   = fpc_pkg::PUMP_REST_RST;
        regs.low_alarm_ms   = fpc_pkg::LOW_ALARM_RST;
        regs.hour_length_ms = fpc_pkg::HOUR_LEN_RST;
        regs.alarm_enable   = fpc_pkg::ALARM_EN_RST;
        raw_prev       = 1'b1;
        level_stable   = 1'b1;
        raw_change_at  = '0;
        in_full        = 1'b1;
        in_empty       = 1'b0;
        pump_run       = 1'b0;
        pump_rest      = 1'b0;
        run_since      = '0;
        rest_since     = '0;
        low_since      = '0;
        low_secs_total = '0;
        alarm_done     = 1'b0;
        slot_started   = '0;
        cur_slot       = '0;
        for (int i = 0; i < fpc_pkg::HOUR_SLOTS; i++)
            slot_total[i] = '0;
        empty_entries  = '0;
        pump_drive     = 1'b0;
    endfunction

    function automatic void store_reg(input logic [fpc_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [31:0] data);
        case (idx)
            fpc_pkg::REG_DEBOUNCE:  regs.debounce_ms    = data[15:0];
            fpc_pkg::REG_PUMP_RUN:  regs.pump_run_ms    = data;
            fpc_pkg::REG_PUMP_REST: regs.pump_rest_ms   = data;
            fpc_pkg::REG_LOW_ALARM: regs.low_alarm_ms   = data;
            fpc_pkg::REG_HOUR_LEN:  regs.hour_length_ms = data;
            fpc_pkg::REG_ALARM_EN:  regs.alarm_enable   = data[0];
            default: ;
        endcase
    endfunction

    // One control pass: debounce, full check, empty check, ring difference,
    // hour advance, pump drive - in that order, all times modulo 2^32.
    function automatic fpc_pkg::result_t run_pass(input logic [31:0] now, input logic raw);
        fpc_pkg::result_t           r;
        fpc_pkg::level_ev_t         ev;
        logic                       pulse;
        logic [31:0]                low_for;
        logic [fpc_pkg::SLOT_W-1:0] oldest;
        ev    = fpc_pkg::EV_NONE;
        pulse = 1'b0;

        if (raw != raw_prev)
            raw_change_at = now;
        if (now - raw_change_at > {16'd0, regs.debounce_ms})
            level_stable = raw;
        raw_prev = raw;

        if (in_full)
        begin
            if (!level_stable)
            begin
                in_empty  = 1'b1;
                in_full   = 1'b0;
                pump_run  = 1'b1;
                pump_rest = 1'b0;
                run_since = now;
                low_since = now;
                empty_entries = empty_entries + 32'd1;
                ev = fpc_pkg::EV_EMPTY;
            end
            slot_total[cur_slot] = low_secs_total;
        end

        // Entered empty above: this runs with zero elapsed low time
        if (in_empty)
        begin
            low_for = now - low_since;
            if (level_stable)
            begin
                in_empty   = 1'b0;
                in_full    = 1'b1;
                pump_run   = 1'b0;
                pump_rest  = 1'b1;
                alarm_done = 1'b0;
                ev = fpc_pkg::EV_FULL;
                low_secs_total = low_secs_total + low_for / MS_PER_S;
            end
            else
            begin
                slot_total[cur_slot] = low_secs_total + low_for / MS_PER_S;
                if (pump_run && (now - run_since) > regs.pump_run_ms)
                begin
                    pump_run   = 1'b0;
                    pump_rest  = 1'b1;
                    rest_since = now;
                end
                if (pump_rest && (now - rest_since) > regs.pump_rest_ms)
                begin
                    pump_run  = 1'b1;
                    pump_rest = 1'b0;
                    run_since = now;
                end
                if (low_for > regs.low_alarm_ms && !alarm_done && regs.alarm_enable)
                begin
                    alarm_done = 1'b1;
                    pulse      = 1'b1;
                end
            end
        end

        oldest = (cur_slot == fpc_pkg::HOUR_SLOTS - 1) ? '0 : cur_slot + 1'b1;
        r.low_secs_24h = slot_total[cur_slot] - slot_total[oldest];

        if (now - slot_started > regs.hour_length_ms)
        begin
            slot_started = now;
            cur_slot     = oldest;
        end

        // Neither phase flag set: hold the drive level
        if (pump_run)
            pump_drive = 1'b1;
        if (pump_rest)
            pump_drive = 1'b0;

        r.flags.pump_on         = pump_drive;
        r.flags.level_event     = ev;
        r.flags.alarm_pulse     = pulse;
        r.flags.trough_empty    = in_empty;
        r.flags.low_event_count = empty_entries;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------

    // Offer one pass; valid stays high on return so a back-to-back pass keeps it up.
    // Every caller lowers it (through settle) before time moves on without a pass.
    task automatic send_pass(input logic [31:0] now, input logic raw);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            pass_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pass_ch.valid     <= 1'b1;
        pass_ch.now_ms    <= now;
        pass_ch.float_raw <= raw;
        do @(posedge clk); while (!pass_ch.ready);
        pending_results.push_back(run_pass(now, raw));
        passes_sent++;
    endtask

    // Stop offering passes and hold until every predicted result has been taken
    task automatic settle();
        pass_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Leaves the write valid high; apply_settings drops it after the last write
    task automatic write_reg(input logic [fpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= data;
        do @(posedge clk); while (!reg_ch.ready);
        store_reg(idx, data);
    endtask

    // Write all six registers while idle; junk in unused data bits must be ignored
    task automatic apply_settings(input logic [15:0] deb, input logic [31:0] run_ms,
                                  input logic [31:0] rest_ms, input logic [31:0] alarm_ms,
                                  input logic [31:0] hour_ms, input logic en,
                                  input bit with_spare);
        logic [31:0] junk;
        junk = $urandom();
        settle();
        write_reg(fpc_pkg::REG_DEBOUNCE,  {junk[31:16], deb});
        write_reg(fpc_pkg::REG_PUMP_RUN,  run_ms);
        write_reg(fpc_pkg::REG_PUMP_REST, rest_ms);
        write_reg(fpc_pkg::REG_LOW_ALARM, alarm_ms);
        write_reg(fpc_pkg::REG_HOUR_LEN,  hour_ms);
        write_reg(fpc_pkg::REG_ALARM_EN,  {junk[31:1], en});
        if (with_spare)
        begin
            write_reg(REG_SPARE_LO, $urandom());
            write_reg(REG_SPARE_HI, $urandom());
        end
        reg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    // Stretches of steady float level with chatter, stalled clocks, far jumps
    // that wrap the time, and some passes at random times as noise
    task automatic run_random_passes(input int count, input int step_max);
        int          left;
        int          stretch;
        logic        lvl;
        logic        raw;
        logic [31:0] step;
        left = count;
        while (left > 0)
        begin
            lvl     = 1'($urandom_range(0, 1));
            stretch = $urandom_range(1, 40);
            for (int k = 0; k < stretch && left > 0; k++)
            begin
                raw = ($urandom_range(0, 7) == 0) ? !lvl : lvl;
                case ($urandom_range(0, 99))
                    0:       step = $urandom();
                    1, 2:    step = '0;
                    3:       step = $urandom() - now_cursor;
                    default: step = $urandom_range(0, step_max);
                endcase
                now_cursor = now_cursor + step;
                send_pass(now_cursor, raw);
                left--;
                // Switch idling on and off now and then so that busy stretches occur too
                if (left % 50 == 0)
                begin
                    src_idle  = ($urandom_range(0, 2) != 0);
                    sink_idle = ($urandom_range(0, 2) != 0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: debounce edge, empty entry, run/rest cycle, alarm, refill, ring
    task automatic test_reset_defaults();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_pass(32'd0,       1'b1);   // pump held low before the first empty
        send_pass(32'd10,      1'b0);   // raw change, not yet stable
        send_pass(32'd60,      1'b0);   // exactly the debounce time: still full
        send_pass(32'd61,      1'b0);   // stable low: empty entered, pump runs
        send_pass(32'd60062,   1'b0);   // run time passed: rest
        send_pass(32'd120063,  1'b0);   // rest time passed: run again
        send_pass(32'd3600062, 1'b0);   // low too long: alarm, hour advance
        send_pass(32'd3600100, 1'b0);   // alarm fires once only
        send_pass(32'd3600200, 1'b1);
        send_pass(32'd3600251, 1'b1);   // stable high: full again
        send_pass(32'd7200300, 1'b1);
        settle();
    endtask

    // Debounce and empty time across the 2^32 wrap of the millisecond clock
    task automatic test_time_wrap();
        send_pass(32'hFFFF_FFF0, 1'b1);
        send_pass(32'hFFFF_FFFF, 1'b0);
        send_pass(32'd64,        1'b0);
        send_pass(32'd200,       1'b1);
        send_pass(32'd251,       1'b1);
        now_cursor = 32'd251;
        settle();
    endtask

    // Alarm masked while disabled, then fires in the same low spell once enabled
    task automatic test_alarm_disable();
        logic [31:0] t0;
        apply_settings(16'd0, 32'd500, 32'd500, 32'd300, 32'd100000, 1'b0, 1'b0);
        t0 = now_cursor;
        send_pass(t0 + 32'd10,  1'b0);
        send_pass(t0 + 32'd11,  1'b0);
        send_pass(t0 + 32'd400, 1'b0);
        send_pass(t0 + 32'd600, 1'b0);
        settle();
        write_reg(fpc_pkg::REG_ALARM_EN, 32'd1);
        reg_ch.valid <= 1'b0;
        send_pass(t0 + 32'd700, 1'b0);
        send_pass(t0 + 32'd800, 1'b0);
        send_pass(t0 + 32'd900, 1'b1);
        send_pass(t0 + 32'd902, 1'b1);
        now_cursor = t0 + 32'd902;
        settle();
    endtask

    // Zero lengths, a one-millisecond hour, then every length at its maximum with the alarm off
    task automatic test_register_extremes();
        apply_settings(16'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1'b1, 1'b1);
        run_random_passes(40, 20);
        apply_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 1'b0, 1'b1);
        run_random_passes(40, 5000);
        settle();
    endtask

    // Hold the receiver off for a long stretch while passes keep coming, so the
    // output queue fills and the input stalls; then drain before moving on
    task automatic test_output_stall();
        apply_settings(16'd20, 32'd300, 32'd200, 32'd2000, 32'd700, 1'b1, 1'b0);
        src_idle     = 1'b0;
        sink_idle    = 1'b0;
        hold_request = 300;
        run_random_passes(40, 100);
        settle();
    endtask

    // Many random settings, each with a long run of random level stretches
    task automatic test_random_settings();
        logic [15:0] deb;
        for (int ph = 0; ph < 8; ph++)
        begin
            deb = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 400));
            apply_settings(deb, $urandom_range(0, 4000), $urandom_range(0, 4000),
                           $urandom_range(0, 20000), $urandom_range(1, 4000),
                           $urandom_range(0, 3) != 0, 1'b0);
            src_idle  = 1'b1;
            sink_idle = 1'b1;
            run_random_passes(200, $urandom_range(50, 800));
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // Result receiver and checker: stalls at random, honours long hold-offs
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int               stall_left;
        int               hold_left;
        fpc_pkg::result_t want;
        res_ch.ready = 1'b0;
        stall_left   = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result item arrived with nothing expected");
                    failures++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    if (res_ch.pump_on !== want.flags.pump_on)
                    begin
                        $error("pump_on: expected %0d, got %0d",
                               want.flags.pump_on, res_ch.pump_on);
                        failures++;
                    end
                    if (res_ch.level_event !== want.flags.level_event)
                    begin
                        $error("level_event: expected %0d, got %0d",
                               want.flags.level_event, res_ch.level_event);
                        failures++;
                    end
                    if (res_ch.alarm_pulse !== want.flags.alarm_pulse)
                    begin
                        $error("alarm_pulse: expected %0d, got %0d",
                               want.flags.alarm_pulse, res_ch.alarm_pulse);
                        failures++;
                    end
                    if (res_ch.trough_empty !== want.flags.trough_empty)
                    begin
                        $error("trough_empty: expected %0d, got %0d",
                               want.flags.trough_empty, res_ch.trough_empty);
                        failures++;
                    end
                    if (res_ch.low_secs_24h !== want.low_secs_24h)
                    begin
                        $error("low_secs_24h: expected %0d, got %0d",
                               want.low_secs_24h, res_ch.low_secs_24h);
                        failures++;
                    end
                    if (res_ch.low_event_count !== want.flags.low_event_count)
                    begin
                        $error("low_event_count: expected %0d, got %0d",
                               want.flags.low_event_count, res_ch.low_event_count);
                        failures++;
                    end
                    if (want.flags.level_event == fpc_pkg::EV_EMPTY)
                        empties_seen++;
                    if (want.flags.level_event == fpc_pkg::EV_FULL)
                        fulls_seen++;
                    if (want.flags.alarm_pulse)
                        alarms_seen++;
                end
                stall_left = sink_idle ? $urandom_range(0, MAX_WAIT) : 0;
            end
            // Pick up a long hold-off request from the stimulus side
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        pass_ch.valid     = 1'b0;
        pass_ch.now_ms    = '0;
        pass_ch.float_raw = 1'b1;
        reg_ch.valid      = 1'b0;
        reg_ch.index      = fpc_pkg::REG_DEBOUNCE;
        reg_ch.data       = '0;
        src_idle          = 1'b1;
        sink_idle         = 1'b1;
        hold_request      = 0;
        now_cursor        = '0;
        failures          = 0;
        cycles            = 0;
        passes_sent       = 0;
        results_checked   = 0;
        empties_seen      = 0;
        fulls_seen        = 0;
        alarms_seen       = 0;
        settings_applied  = 0;
        clear_model();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_time_wrap();
        test_alarm_disable();
        test_register_extremes();
        test_output_stall();
        test_random_settings();

        // Everything predicted has arrived; allow time for any stray extra result
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            failures++;
        end

        $display("Checked %0d of %0d passes over %0d register settings;",
                 results_checked, passes_sent, settings_applied);
        $display("saw %0d empty entries, %0d refills and %0d alarm pulses, %0d errors.",
                 empties_seen, fulls_seen, alarms_seen, failures);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[float_pump_controller.f]
hdl/fpc_pkg.sv
hdl/fpc_if.sv
hdl/fpc_ram.sv
hdl/fpc_ctrl.sv
hdl/fpc_ring.sv
hdl/fpc_fifo.sv
hdl/float_pump_controller.sv
bench/testbench.sv
